@@ rtl/tcw_pkg.sv @@
// Shared types, constants and the color table of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 4;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic              OP_PUT       = 1'b0;
  localparam logic              OP_READ      = 1'b1;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] WHITE_ATTR   = 4'hF;
  localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_CHAR, WHITE_ATTR};

  typedef struct packed {
    logic              opcode;
    logic [CHAR_W-1:0] char_code;
    logic [3:0]        color_type;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic              scrolled;
  } out_t;

  // classified request kinds handed from front to back
  typedef enum logic [1:0] {
    K_NEWLINE = 2'd0,
    K_CHAR    = 2'd1,
    K_READ    = 2'd2,
    K_NONE    = 2'd3   // read outside the screen
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attr;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
  } cmd_t;

  function automatic logic [ATTR_W-1:0] attr_of(input logic [3:0] color_type);
    logic [ATTR_W-1:0] a;
    case (color_type)
      4'd0:    a = 4'h F;
      4'd1:    a = 4'h4;
      4'd2:    a = 4'hE;
      4'd3:    a = 4'h1;
      4'd4:    a = 4'h2;
      4'd5:    a = 4'h3;
      4'd6:    a = 4'h5;
      4'd7:    a = 4'h6;
      4'd8:    a = 4'h7;
      4'd9:    a = 4'h8;
      4'd10:   a = 4'h9;
      4'd11:   a = 4'hA;
      4'd12:   a = 4'hB;
      4'd13:   a = 4'hC;
      4'd14:   a = 4'hD;
      default: a = WHITE_ATTR;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/text_console_writer_unit.sv @@
// Text console writer: front classifier, request queue and screen back end.
// A put passes the write and output states, a read the read, read-wait
// and output states, a newline goes straight to output; a scroll adds a
// pass that blanks the new bottom row. The back end takes a request only
// when idle with no result pending, using a single-port screen memory;
// scrolling rotates rows, no copying. Reset: cursor goes home and a
// clearing pass blanks all ROWS*COLUMNS cells with cmd_stall held high.
`timescale 1ns / 1ps
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  tcw_pkg::in_t  cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output tcw_pkg::out_t res
);
  import tcw_pkg::*;

  logic clearing;
  logic push_valid;
  logic push_full;
  cmd_t push_data;
  logic pop_valid;
  logic pop;
  cmd_t pop_data;

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .push_valid(push_valid),
    .push_full (push_full),
    .push_data (push_data)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_full (push_full),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop      (pop),
    .pop_data (pop_data),
    .clearing (clearing),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

endmodule

@@ rtl/tcw_front.sv @@
// Front end: takes requests, classifies them and looks up the attribute.
`timescale 1ns / 1ps
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         clearing,
  input  logic         cmd_valid,
  output logic         cmd_stall,
  input  tcw_pkg::in_t cmd,
  output logic         push_valid,
  input  logic         push_full,
  output tcw_pkg::cmd_t push_data
);
  import tcw_pkg::*;

  logic fr_valid;
  cmd_t fr_cmd;
  cmd_t cls;

  always_comb begin
    cls.char_code = cmd.char_code;
    cls.attr      = attr_of(cmd.color_type);
    cls.cell_row  = cmd.cell_row;
    cls.cell_col  = cmd.cell_col;
    if (cmd.opcode == OP_PUT) begin
      cls.kind = (cmd.char_code == NEWLINE_CHAR) ? K_NEWLINE : K_CHAR;
    end else if ((cmd.cell_row >= ROWS) || (cmd.cell_col >= COLUMNS)) begin
      cls.kind = K_NONE;
    end else begin
      cls.kind = K_READ;
    end
  end

  assign cmd_stall  = clearing || (fr_valid && push_full);
  assign push_valid = fr_valid;
  assign push_data  = fr_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      fr_valid <= 1'b1;
    end else if (fr_valid && !push_full) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      fr_cmd <= cls;
    end
  end

endmodule

@@ rtl/tcw_queue.sv @@
// Two-entry queue of classified requests between front and back.
`timescale 1ns / 1ps
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_full,
  input  tcw_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output tcw_pkg::cmd_t pop_data
);
  import tcw_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_full = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/tcw_back.sv @@
// Back end: screen memory, cursor, scroll by row rotation, result register.
`timescale 1ns / 1ps
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop,
  input  tcw_pkg::cmd_t pop_data,
  output logic          clearing,
  output logic          res_valid,
  input  logic          res_stall,
  output tcw_pkg::out_t res
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int BW    = $clog2(COLUMNS);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_BLANK = 7'b0000100,
    ST_WRITE = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_RWAIT = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t            state;
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data;
  logic [AW-1:0]     clr_addr;
  logic [BW-1:0]     blank_col;
  logic [RW-1:0]     cursor_row;   // logical row
  logic [RW-1:0]     cursor_prow;  // physical row in memory
  logic [CW-1:0]     cursor_col;
  logic [RW-1:0]     top;          // physical row shown as row 0
  logic [RW-1:0]     rd_prow;
  cmd_t              cur;
  logic [CHAR_W-1:0] res_char;
  logic [ATTR_W-1:0] res_attr;
  logic              res_scrolled;

  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [CELL_W-1:0] mem_wdata;
  logic [RW-1:0]     prow_inc;
  logic [RW-1:0]     top_inc;
  logic              last_row;
  logic [RW:0]       rd_sum;

  assign prow_inc = (cursor_prow == RW'(ROWS - 1)) ? '0 : RW'(cursor_prow + 1'b1);
  assign top_inc  = (top == RW'(ROWS - 1)) ? '0 : RW'(top + 1'b1);
  assign last_row = (cursor_row == RW'(ROWS - 1));
  assign rd_sum   = {1'b0, RW'(pop_data.cell_row)} + {1'b0, top};

  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_IDLE) && pop_valid && !res_valid;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = clr_addr;
    mem_wdata = BLANK_CELL;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_BLANK: begin
        mem_we   = 1'b1;
        mem_addr = AW'(cursor_prow * COLUMNS + blank_col);
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(cursor_prow * COLUMNS + cursor_col);
        mem_wdata = {cur.char_code, cur.attr};
      end
      ST_READ: begin
        mem_addr = AW'(rd_prow * COLUMNS + cur.cell_col);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (state == ST_READ) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      blank_col    <= '0;
      cursor_row   <= '0;
      cursor_prow  <= '0;
      cursor_col   <= '0;
      top          <= '0;
      res_valid    <= 1'b0;
      res_scrolled <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            cur       <= pop_data;
            blank_col <= '0;
            case (pop_data.kind)
              K_NEWLINE: begin
                res_char     <= '0;
                res_attr     <= '0;
                res_scrolled <= last_row;
                cursor_col   <= '0;
                cursor_prow  <= prow_inc;
                if (last_row) begin
                  top   <= top_inc;
                  state <= ST_BLANK;
                end else begin
                  cursor_row <= RW'(cursor_row + 1'b1);
                  state      <= ST_OUT;
                end
              end
              K_CHAR: begin
                res_char <= pop_data.char_code;
                res_attr <= pop_data.attr;
                if (cursor_col == CW'(COLUMNS)) begin
                  cursor_col   <= '0;
                  cursor_prow  <= prow_inc;
                  res_scrolled <= last_row;
                  if (last_row) begin
                    top   <= top_inc;
                    state <= ST_BLANK;
                  end else begin
                    cursor_row <= RW'(cursor_row + 1'b1);
                    state      <= ST_WRITE;
                  end
                end else begin
                  res_scrolled <= 1'b0;
                  state        <= ST_WRITE;
                end
              end
              K_READ: begin
                res_scrolled <= 1'b0;
                rd_prow <= (rd_sum >= (RW + 1)'(ROWS)) ? RW'(rd_sum - (RW + 1)'(ROWS))
                                                       : RW'(rd_sum);
                state   <= ST_READ;
              end
              default: begin
                res_char     <= '0;
                res_attr     <= '0;
                res_scrolled <= 1'b0;
                state        <= ST_OUT;
              end
            endcase
          end
        end
        ST_BLANK: begin
          // wipe the new bottom row, which reuses the old top row's storage
          if (blank_col == BW'(COLUMNS - 1)) begin
            state <= (cur.kind == K_CHAR) ? ST_WRITE : ST_OUT;
          end else begin
            blank_col <= blank_col + 1'b1;
          end
        end
        ST_WRITE: begin
          cursor_col <= CW'(cursor_col + 1'b1);
          state      <= ST_OUT;
        end
        ST_READ: begin
          state <= ST_RWAIT;
        end
        ST_RWAIT: begin
          res_char <= rd_data[CELL_W-1:ATTR_W];
          res_attr <= rd_data[ATTR_W-1:0];
          state    <= ST_OUT;
        end
        ST_OUT: begin
          res_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT) begin
      res.cursor_pos <= POS_W'(cursor_row * COLUMNS + cursor_col);
      res.cell_char  <= res_char;
      res.cell_attr  <= res_attr;
      res.scrolled   <= res_scrolled;
    end
  end

endmodule

@@ test/tb_text_console_writer_unit.sv @@
// Self-checking testbench for the text console writer: puts, reads, wrap, scroll.
`timescale 1ns / 1ps
module tb_text_console_writer_unit;
  import tcw_pkg::*;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = ROWS * COLUMNS;
  localparam int RAND_REQS = 500;
  // color type 0..14 -> attribute, entry t at bits [4t+3:4t]
  localparam logic [15*ATTR_W-1:0] COLOR_ATTRS = {
    4'hD, 4'hC, 4'hB, 4'hA, 4'h9, 4'h8, 4'h7, 4'h6,
    4'h5, 4'h3, 4'h2, 4'h1, 4'hE, 4'h4, 4'hF
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  in_t  cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  out_t res;

  text_console_writer_unit dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #5 clk = ~clk;

  // console shadow
  logic [CELL_W-1:0] shadow_screen [0:CELLS-1];
  int cur_row = 0;
  int cur_col = 0;

  in_t  pending_requests [$];
  out_t expected_results [$];
  int   failures = 0;
  int   results_seen = 0;
  logic quiet = 1'b0;

  // generator-side cursor guess, only used to aim reads at fresh text
  int gen_row = 0;
  int gen_col = 0;

  function automatic logic start_next_line();
    logic did_scroll;
    did_scroll = 1'b0;
    cur_col = 0;
    if (cur_row + 1 >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
        shadow_screen[i] = shadow_screen[i + COLUMNS];
      for (int c = 0; c < COLUMNS; c++)
        shadow_screen[(ROWS - 1) * COLUMNS + c] = BLANK_CELL;
      cur_row = ROWS - 1;
      did_scroll = 1'b1;
    end else begin
      cur_row++;
    end
    return did_scroll;
  endfunction

  function automatic out_t predict_console(in_t req);
    out_t exp_res;
    logic [ATTR_W-1:0] attr;
    int idx;
    exp_res = '0;
    if (req.opcode == OP_PUT) begin
      if (req.char_code == NEWLINE_CHAR) begin
        exp_res.scrolled = start_next_line();
      end else begin
        attr = (req.color_type < 15) ? COLOR_ATTRS[req.color_type * 4 +: 4] : WHITE_ATTR;
        if (cur_col >= COLUMNS) exp_res.scrolled = start_next_line();
        idx = cur_row * COLUMNS + cur_col;
        if (idx < CELLS) shadow_screen[idx] = {req.char_code, attr};
        cur_col++;
        exp_res.cell_char = req.char_code;
        exp_res.cell_attr = attr;
      end
    end else if (req.cell_row < ROWS && req.cell_col < COLUMNS) begin
      {exp_res.cell_char, exp_res.cell_attr} =
        shadow_screen[req.cell_row * COLUMNS + req.cell_col];
    end
    exp_res.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
    return exp_res;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic add_put(input logic [CHAR_W-1:0] ch, input logic [3:0] color);
    in_t req;
    req.opcode     = OP_PUT;
    req.char_code  = ch;
    req.color_type = color;
    req.cell_row   = ROW_W'($urandom_range(0, 31));
    req.cell_col   = COL_W'($urandom_range(0, 127));
    pending_requests.push_back(req);
    if (ch == NEWLINE_CHAR || gen_col >= COLUMNS) begin
      gen_col = 0;
      if (gen_row < ROWS - 1) gen_row++;
    end
    if (ch != NEWLINE_CHAR) gen_col++;
  endtask

  task automatic add_read(input int row, input int col);
    in_t req;
    req.opcode     = OP_READ;
    req.char_code  = CHAR_W'($urandom_range(0, 255));
    req.color_type = 4'($urandom_range(0, 15));
    req.cell_row   = ROW_W'(row);
    req.cell_col   = COL_W'(col);
    pending_requests.push_back(req);
  endtask

  // sender
  always @(posedge clk) begin
    logic take;
    int   gap_left;
    if (rst) begin
      cmd_valid <= 1'b0;
      gap_left = 0;
    end else begin
      take = cmd_valid && !cmd_stall;
      if (take) begin
        expected_results.push_back(predict_console(cmd));
        gap_left = draw_gap();
        if ($urandom_range(0, 39) == 0) quiet <= ~quiet;
      end
      if (take || !cmd_valid) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          cmd       <= pending_requests.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure, with one long hold-off to fill the block
  always @(posedge clk) begin
    int   stall_left;
    logic long_hold_done;
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
      long_hold_done = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (!long_hold_done && results_seen >= 60) begin
      long_hold_done = 1'b1;
      stall_left = 399;
      res_stall <= 1'b1;
    end else begin
      stall_left = draw_gap();
      res_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t exp_res;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: result expected none actual %h", $time, res);
      end else begin
        exp_res = expected_results.pop_front();
        if (res.cursor_pos !== exp_res.cursor_pos) begin
          failures++;
          $display("%0t: cursor_pos expected %0d actual %0d", $time,
                   exp_res.cursor_pos, res.cursor_pos);
        end
        if (res.cell_char !== exp_res.cell_char) begin
          failures++;
          $display("%0t: cell_char expected %h actual %h", $time,
                   exp_res.cell_char, res.cell_char);
        end
        if (res.cell_attr !== exp_res.cell_attr) begin
          failures++;
          $display("%0t: cell_attr expected %h actual %h", $time,
                   exp_res.cell_attr, res.cell_attr);
        end
        if (res.scrolled !== exp_res.scrolled) begin
          failures++;
          $display("%0t: scrolled expected %b actual %b", $time,
                   exp_res.scrolled, res.scrolled);
        end
      end
    end
  end

  initial begin
    int rand_count;
    int line_len;
    int r;
    in_t noise;
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = BLANK_CELL;

    // directed: reads at reset, edges of the screen and beyond it
    add_read(0, 0);
    add_read(ROWS - 1, COLUMNS - 1);
    add_read(ROWS, 0);
    add_read(0, COLUMNS);
    add_read(31, 127);
    // every color type, with character zero and 0xFF at the ends
    for (int t = 0; t < 16; t++) begin
      if (t == 0) add_put(8'h00, 4'(t));
      else if (t == 15) add_put(8'hFF, 4'(t));
      else add_put(CHAR_W'($urandom_range(11, 254)), 4'(t));
    end
    add_put(NEWLINE_CHAR, 4'($urandom_range(0, 15)));
    add_read(0, 0);
    add_read(0, 15);
    add_read(1, 0);

    // random: lines of text, runs of blank lines, reads aimed at fresh text, noise
    rand_count = 0;
    while (rand_count < RAND_REQS) begin
      r = $urandom_range(0, 99);
      if (r < 60) line_len = $urandom_range(0, 12);
      else if (r < 85) line_len = $urandom_range(13, 40);
      else if (r < 92) line_len = COLUMNS;
      else line_len = $urandom_range(COLUMNS - 2, COLUMNS + 25);
      for (int k = 0; k < line_len; k++)
        add_put(CHAR_W'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      rand_count += line_len;
      for (int k = $urandom_range(0, 3); k > 0; k--) begin
        r = $urandom_range(0, 99);
        if (r < 70)
          add_read(gen_row - $urandom_range(0, (gen_row > 0) ? 1 : 0),
                   $urandom_range(0, COLUMNS - 1));
        else if (r < 90) add_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
        else add_read($urandom_range(0, 31), $urandom_range(0, 127));
        rand_count++;
      end
      if ($urandom_range(0, 19) == 0) begin
        noise = in_t'($urandom);
        if (noise.opcode == OP_PUT) add_put(noise.char_code, noise.color_type);
        else add_read(noise.cell_row, noise.cell_col);
        rand_count++;
      end
      for (int k = ($urandom_range(0, 9) < 3) ? $urandom_range(2, 6) : 1; k > 0; k--) begin
        add_put(NEWLINE_CHAR, 4'($urandom_range(0, 15)));
        rand_count++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() > 0 || cmd_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
